@@ sv/clcd_pkg.sv @@
package clcd_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    // configuration register indexes
    localparam logic [1:0] CFG_BYTE_DELAY = 2'd0;
    localparam logic [1:0] CFG_STROBE     = 2'd1;
    localparam logic [1:0] CFG_CLEAR_WAIT = 2'd2;
    localparam logic [1:0] CFG_LINE_LEN   = 2'd3;

    localparam logic [15:0] BYTE_DELAY_RST = 16'd1000;
    localparam logic [7:0]  STROBE_RST     = 8'd1;
    localparam logic [15:0] CLEAR_WAIT_RST = 16'd3000;
    localparam logic [5:0]  LINE_LEN_RST   = 6'd16;

    // operation codes
    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_CMD   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_CHAR  = 2'd3;

    localparam logic [7:0] CMD_LINE_TWO = 8'hC0;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_BREAK   = 8'h5C;

    localparam logic [2:0] INIT_LAST_IDX = 3'd4;
    localparam logic [2:0] PHASE_LAST    = 3'd5;

    typedef enum logic [2:0] {
        JOB_INIT,
        JOB_CMD,
        JOB_CLEAR,
        JOB_LINE2,
        JOB_CHAR,
        JOB_LINE2_CHAR
    } t_job_kind;

    typedef struct packed {
        t_job_kind  kind;
        logic [7:0] value;
    } t_job;

    typedef struct packed {
        logic [15:0] byte_delay_us;
        logic [7:0]  strobe_us;
        logic [15:0] clear_wait_us;
        logic [5:0]  line_length;
    } t_cfg;

    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h33;
            3'd1:    b = 8'h32;
            3'd2:    b = 8'h28;
            3'd3:    b = 8'h0C;
            3'd4:    b = 8'h06;
            default: b = 8'h06;
        endcase
        return b;
    endfunction

endpackage

@@ sv/clcd_front.sv @@
module clcd_front
    import clcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_accept,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_value,
    output logic       o_push,
    output t_job       o_job
);

    logic       r_second, n_second;
    logic [5:0] r_column, n_column;
    logic       r_done,   n_done;
    logic       job_ok;
    t_job       job;
    logic       ends, brk, full;

    assign ends = (i_value == CHAR_NUL);
    assign brk  = (i_value == CHAR_BREAK);
    assign full = (r_column >= i_cfg.line_length);

    always_comb begin
        n_second  = r_second;
        n_column  = r_column;
        n_done    = r_done;
        job_ok    = 1'b0;
        job.kind  = JOB_CMD;
        job.value = i_value;
        unique case (i_operation)
            OP_INIT: begin
                job_ok   = 1'b1;
                job.kind = JOB_INIT;
            end
            OP_CMD: begin
                job_ok   = 1'b1;
                job.kind = JOB_CMD;
            end
            OP_CLEAR: begin
                job_ok   = 1'b1;
                job.kind = JOB_CLEAR;
                n_second = 1'b0;
                n_column = 6'd0;
                n_done   = 1'b0;
            end
            default: begin
                if (r_done) begin
                    job_ok = 1'b0;
                end else if (!r_second) begin
                    job_ok = 1'b1;
                    if (full || ends || brk) begin
                        n_second = 1'b1;
                        n_column = 6'd0;
                        job.kind = JOB_LINE2;
                        if (ends) begin
                            n_done = 1'b1;
                        end else if (!brk) begin
                            // full line one: the character opens line two, unless the line length is zero
                            if (i_cfg.line_length == 6'd0) begin
                                n_done = 1'b1;
                            end else begin
                                job.kind = JOB_LINE2_CHAR;
                                n_column = 6'd1;
                            end
                        end
                    end else begin
                        job.kind = JOB_CHAR;
                        n_column = r_column + 6'd1;
                    end
                end else if (ends || brk || full) begin
                    n_done = 1'b1;
                end else begin
                    job_ok   = 1'b1;
                    job.kind = JOB_CHAR;
                    n_column = r_column + 6'd1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
            r_column <= 6'd0;
            r_done   <= 1'b0;
        end else if (i_accept) begin
            r_second <= n_second;
            r_column <= n_column;
            r_done   <= n_done;
        end
    end

    assign o_push = i_accept && job_ok;
    assign o_job  = job;

endmodule

@@ sv/clcd_queue.sv @@
module clcd_queue
    import clcd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

endmodule

@@ sv/clcd_back.sv @@
module clcd_back
    import clcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_job_valid,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_reg_select,
    output logic [3:0]  o_data_nibble,
    output logic        o_enable,
    output logic [15:0] o_hold_us,
    output logic        o_last
);

    logic [2:0]  r_byte_idx;
    logic [2:0]  r_phase;
    logic        r_valid;
    logic        r_rs;
    logic [3:0]  r_nib;
    logic        r_en;
    logic [15:0] r_hold;
    logic        r_last;

    logic        adv;
    logic        last_byte;
    logic        last_phase;
    logic [7:0]  cur_byte;
    logic        cur_rs;
    logic [16:0] sum_first;
    logic [16:0] sum_clear;
    logic [15:0] hold;

    assign adv = i_job_valid && (!r_valid || !i_out_stall);

    always_comb begin
        cur_byte  = i_job.value;
        cur_rs    = 1'b0;
        last_byte = 1'b1;
        unique case (i_job.kind)
            JOB_INIT: begin
                cur_byte  = init_byte(r_byte_idx);
                last_byte = (r_byte_idx == INIT_LAST_IDX);
            end
            JOB_CMD:   cur_byte = i_job.value;
            JOB_CLEAR: cur_byte = CMD_CLEAR;
            JOB_LINE2: cur_byte = CMD_LINE_TWO;
            JOB_CHAR: begin
                cur_byte = i_job.value;
                cur_rs   = 1'b1;
            end
            JOB_LINE2_CHAR: begin
                last_byte = (r_byte_idx != 3'd0);
                cur_byte  = last_byte ? i_job.value : CMD_LINE_TWO;
                cur_rs    = last_byte;
            end
            default: cur_byte = i_job.value;
        endcase
    end

    assign last_phase = (r_phase == PHASE_LAST);
    assign sum_first  = {1'b0, i_cfg.byte_delay_us} + {9'd0, i_cfg.strobe_us};
    assign sum_clear  = {1'b0, i_cfg.clear_wait_us} + {9'd0, i_cfg.strobe_us};

    always_comb begin
        hold = {8'd0, i_cfg.strobe_us};
        if (r_phase == 3'd0) begin
            hold = sum_first[16] ? 16'hFFFF : sum_first[15:0];
        end else if (last_phase && (i_job.kind == JOB_CLEAR)) begin
            hold = sum_clear[16] ? 16'hFFFF : sum_clear[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_idx <= 3'd0;
            r_phase    <= 3'd0;
            r_valid    <= 1'b0;
        end else begin
            if (adv) begin
                r_valid <= 1'b1;
                if (last_phase) begin
                    r_phase    <= 3'd0;
                    r_byte_idx <= last_byte ? 3'd0 : r_byte_idx + 3'd1;
                end else begin
                    r_phase <= r_phase + 3'd1;
                end
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rs   <= cur_rs;
            r_nib  <= (r_phase < 3'd3) ? cur_byte[7:4] : cur_byte[3:0];
            r_en   <= (r_phase == 3'd1) || (r_phase == 3'd4);
            r_hold <= hold;
            r_last <= last_byte && last_phase;
        end
    end

    assign o_pop         = adv && last_byte && last_phase;
    assign o_out_valid   = r_valid;
    assign o_reg_select  = r_rs;
    assign o_data_nibble = r_nib;
    assign o_enable      = r_en;
    assign o_hold_us     = r_hold;
    assign o_last        = r_last;

endmodule

@@ sv/char_lcd_4bit_writer.sv @@
// Character LCD writer for a 4-bit bus, two text lines.
// Input channel (i_in_valid / o_in_stall) takes one item: an operation
// (init, raw command, clear, message character) and a byte value.
// Output channel (o_out_valid / i_out_stall) gives one item per pin phase:
// RS, D7..D4, E and the hold time in microseconds; o_last marks the final
// phase of an input. Every byte is six phases, high nibble first.
// Init gives 30 phases, command and clear 6, a message character 0, 6 or 12.
// An accepted item passes through the job queue, then the output register.
// Throughput: one phase per cycle while the receiver does not stall, set
// by the phase sequencer in the back end; characters that give no phases
// are absorbed in the front end. A small job queue sits between front and
// back, so input is taken while phases still go out. A receiver stall
// holds the output register; the back end then waits and the queue fills,
// after which o_in_stall rises. Reset clears the text position, the queue
// and the output valid, and loads the configuration defaults.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data;
// the user must do this only while the block is idle; nothing enforces it.
module char_lcd_4bit_writer
    import clcd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_reg_select,
    output logic [3:0]  o_data_nibble,
    output logic        o_enable,
    output logic [15:0] o_hold_us,
    output logic        o_last
);

    t_cfg r_cfg;
    logic accept;
    logic push, pop, q_full, q_valid;
    t_job push_job, head_job;

    // configuration registers, truncated to their own widths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.byte_delay_us <= BYTE_DELAY_RST;
            r_cfg.strobe_us     <= STROBE_RST;
            r_cfg.clear_wait_us <= CLEAR_WAIT_RST;
            r_cfg.line_length   <= LINE_LEN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BYTE_DELAY: r_cfg.byte_delay_us <= i_cfg_data;
                CFG_STROBE:     r_cfg.strobe_us     <= i_cfg_data[7:0];
                CFG_CLEAR_WAIT: r_cfg.clear_wait_us <= i_cfg_data;
                CFG_LINE_LEN:   r_cfg.line_length   <= i_cfg_data[5:0];
                default:        r_cfg.line_length   <= r_cfg.line_length;
            endcase
        end
    end

    // hold off input only while the job queue is full
    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    clcd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (accept),
        .i_operation (i_operation),
        .i_value     (i_value),
        .o_push      (push),
        .o_job       (push_job)
    );

    clcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    clcd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_job_valid   (q_valid),
        .i_job         (head_job),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_reg_select  (o_reg_select),
        .o_data_nibble (o_data_nibble),
        .o_enable      (o_enable),
        .o_hold_us     (o_hold_us),
        .o_last        (o_last)
    );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import clcd_pkg::*;

    // Watchdog limit: idle cycles with no item moving on either channel.
    // Covers the long receiver hold-off plus the longest random gaps.
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int HOLD_OFF_CYCLES = 250;
    // Cycles to let a character that gives no phases settle before a config write.
    localparam int SETTLE_CYCLES   = 8;
    localparam int RANDOM_PER_SET  = 20;

    localparam logic [7:0] POWER_UP_SEQ [0:4] = '{8'h33, 8'h32, 8'h28, 8'h0C, 8'h06};

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] val;
    } t_lcd_req;

    typedef struct packed {
        logic        rs;
        logic [3:0]  nib;
        logic        en;
        logic [15:0] hold;
        logic        last;
    } t_lcd_phase;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_operation = '0;
    logic [7:0]  i_value     = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_reg_select;
    logic [3:0]  o_data_nibble;
    logic        o_enable;
    logic [15:0] o_hold_us;
    logic        o_last;

    char_lcd_4bit_writer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_reg_select  (o_reg_select),
        .o_data_nibble (o_data_nibble),
        .o_enable      (o_enable),
        .o_hold_us     (o_hold_us),
        .o_last        (o_last)
    );

    always #1 i_clk = ~i_clk;

    // Configuration mirror, loaded with the reset defaults.
    logic [15:0] cfg_byte_delay = BYTE_DELAY_RST;
    logic [7:0]  cfg_strobe     = STROBE_RST;
    logic [15:0] cfg_clear_wait = CLEAR_WAIT_RST;
    logic [5:0]  cfg_line_len   = LINE_LEN_RST;

    // Text position mirror.
    logic       txt_on_line2 = 1'b0;
    logic [5:0] txt_column   = '0;
    logic       txt_msg_done = 1'b0;

    t_lcd_req   pending_reqs [$];
    t_lcd_phase pin_phases_q [$];
    t_lcd_req   next_req;
    t_lcd_phase exp_phase;

    int  err_count     = 0;
    int  send_gap      = 0;
    int  stall_left    = 0;
    int  hold_left     = 0;
    int  hold_off_ask  = 0;
    int  hold_off_done = 0;
    int  idle_cycles   = 0;
    bit  quiet_mode    = 1'b0;

    // ------------------------------------------------------------------
    // Pin phase predictor
    // ------------------------------------------------------------------
    function automatic logic [15:0] hold_sum(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    // One byte is two nibbles, each E low / E high / E low; the byte delay
    // folds into the very first phase.
    function automatic void add_byte(logic [7:0] b, logic rs);
        t_lcd_phase p;
        for (int half = 0; half < 2; half++) begin
            p.rs   = rs;
            p.nib  = (half == 0) ? b[7:4] : b[3:0];
            p.last = 1'b0;
            p.en   = 1'b0;
            p.hold = (half == 0) ? hold_sum(cfg_byte_delay, {8'd0, cfg_strobe})
                                 : {8'd0, cfg_strobe};
            pin_phases_q.push_back(p);
            p.hold = {8'd0, cfg_strobe};
            p.en   = 1'b1;
            pin_phases_q.push_back(p);
            p.en   = 1'b0;
            pin_phases_q.push_back(p);
        end
    endfunction

    function automatic void text_char(logic [7:0] c);
        logic is_nul;
        logic is_break;
        is_nul   = (c == CHAR_NUL);
        is_break = (c == CHAR_BREAK);
        if (txt_msg_done)
            return;
        if (!txt_on_line2) begin
            // full first line, backslash or NUL: move to line two
            if (txt_column >= cfg_line_len || is_nul || is_break) begin
                add_byte(CMD_LINE_TWO, 1'b0);
                txt_on_line2 = 1'b1;
                txt_column   = '0;
                if (is_nul) begin
                    txt_msg_done = 1'b1;
                    return;
                end
                if (is_break)
                    return;
            end
        end else if (is_nul || is_break) begin
            txt_msg_done = 1'b1;
            return;
        end
        if (txt_column >= cfg_line_len) begin
            txt_msg_done = 1'b1;
            return;
        end
        add_byte(c, 1'b1);
        txt_column = txt_column + 6'd1;
    endfunction

    function automatic void predict_phases(logic [1:0] op, logic [7:0] val);
        int         n0;
        t_lcd_phase p;
        n0 = pin_phases_q.size();
        case (op)
            OP_INIT: begin
                for (int i = 0; i < 5; i++)
                    add_byte(POWER_UP_SEQ[i], 1'b0);
            end
            OP_CMD: begin
                add_byte(val, 1'b0);
            end
            OP_CLEAR: begin
                add_byte(CMD_CLEAR, 1'b0);
                p = pin_phases_q.pop_back();
                p.hold = hold_sum({8'd0, cfg_strobe}, cfg_clear_wait);
                pin_phases_q.push_back(p);
                txt_on_line2 = 1'b0;
                txt_column   = '0;
                txt_msg_done = 1'b0;
            end
            default: begin
                text_char(val);
            end
        endcase
        if (pin_phases_q.size() > n0) begin
            p = pin_phases_q.pop_back();
            p.last = 1'b1;
            pin_phases_q.push_back(p);
        end
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_text_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return CHAR_BREAK;
        else if (r < 70)
            return 8'($urandom_range(32, 126));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------
    // Driver: present queued items, predict on acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall)
                predict_phases(i_operation, i_value);
            // hold a stalled item; otherwise advance
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    next_req = pending_reqs.pop_front();
                    i_in_valid  <= 1'b1;
                    i_operation <= next_req.op;
                    i_value     <= next_req.val;
                    send_gap = (quiet_mode || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall: random gaps plus the requested long hold-off
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_off_done != hold_off_ask) begin
            hold_off_done = hold_off_done + 1;
            hold_left = HOLD_OFF_CYCLES;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (!quiet_mode && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check every accepted pin phase against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pin_phases_q.size() == 0) begin
                err_count = err_count + 1;
                if (err_count <= 10)
                    $display("unexpected phase: rs=%0d nib=%h en=%0d hold=%0d last=%0d",
                             o_reg_select, o_data_nibble, o_enable, o_hold_us, o_last);
            end else begin
                exp_phase = pin_phases_q.pop_front();
                if (o_reg_select !== exp_phase.rs || o_data_nibble !== exp_phase.nib ||
                    o_enable !== exp_phase.en || o_hold_us !== exp_phase.hold ||
                    o_last !== exp_phase.last) begin
                    err_count = err_count + 1;
                    if (err_count <= 10)
                        $display("phase mismatch: exp rs=%0d nib=%h en=%0d hold=%0d last=%0d",
                                 exp_phase.rs, exp_phase.nib, exp_phase.en,
                                 exp_phase.hold, exp_phase.last,
                                 " | got rs=%0d nib=%h en=%0d hold=%0d last=%0d",
                                 o_reg_select, o_data_nibble, o_enable, o_hold_us, o_last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: drop the run when nothing moves for too long
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequencing
    // ------------------------------------------------------------------
    task automatic queue_req(logic [1:0] op, logic [7:0] val);
        t_lcd_req r;
        r.op  = op;
        r.val = val;
        pending_reqs.push_back(r);
    endtask

    // Wait until every item is taken and every phase checked, then let
    // the front end settle.
    task automatic drain();
        while (pending_reqs.size() != 0 || i_in_valid || pin_phases_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_BYTE_DELAY: cfg_byte_delay = data;
            CFG_STROBE:     cfg_strobe     = data[7:0];
            CFG_CLEAR_WAIT: cfg_clear_wait = data;
            default:        cfg_line_len   = data[5:0];
        endcase
    endtask

    // Narrow registers get random upper data bits; the block must ignore them.
    task automatic set_config(logic [15:0] bd, logic [7:0] st, logic [15:0] cw,
                              logic [5:0] len);
        write_reg(CFG_BYTE_DELAY, bd);
        write_reg(CFG_STROBE, {8'($urandom_range(0, 255)), st});
        write_reg(CFG_CLEAR_WAIT, cw);
        write_reg(CFG_LINE_LEN, {10'($urandom_range(0, 1023)), len});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly a clear followed by a message of random text, the rest
    // init, raw commands and noise.
    task automatic queue_random_mix(int count);
        int n;
        int r;
        int len;
        int max_len;
        n = 0;
        while (n < count) begin
            r = $urandom_range(0, 9);
            if (r < 6) begin
                max_len = (cfg_line_len <= 6) ? 2 * cfg_line_len + 3 : 10;
                len = $urandom_range(1, max_len);
                queue_req(OP_CLEAR, 8'($urandom_range(0, 255)));
                for (int k = 0; k < len; k++)
                    queue_req(OP_CHAR, pick_text_char());
                if ($urandom_range(0, 2) == 0)
                    queue_req(OP_CHAR, CHAR_NUL);
                n = n + len + 1;
            end else if (r == 6) begin
                queue_req(OP_INIT, 8'($urandom_range(0, 255)));
                n = n + 1;
            end else if (r == 7) begin
                queue_req(OP_CMD, 8'($urandom_range(0, 255)));
                n = n + 1;
            end else begin
                queue_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                n = n + 1;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Defaults: init, raw commands, clear, line break and message end
        queue_req(OP_INIT, 8'hFF);
        queue_req(OP_CMD, 8'h00);
        queue_req(OP_CMD, 8'hFF);
        queue_req(OP_CMD, 8'hA5);
        queue_req(OP_CLEAR, 8'hFF);
        queue_req(OP_CHAR, "H");
        queue_req(OP_CHAR, 8'h80);
        queue_req(OP_CHAR, CHAR_BREAK);     // break on line one
        queue_req(OP_CHAR, "A");
        queue_req(OP_CHAR, CHAR_BREAK);     // break on line two ends message
        queue_req(OP_CHAR, "B");            // ignored after end
        queue_req(OP_CLEAR, 8'h00);
        queue_req(OP_CHAR, CHAR_NUL);       // NUL on line one: move and end
        queue_req(OP_CHAR, "x");
        queue_req(OP_CLEAR, 8'h00);
        queue_req(OP_CHAR, "q");
        queue_req(OP_CHAR, CHAR_BREAK);
        queue_req(OP_CHAR, CHAR_NUL);       // NUL on line two
        drain();

        // One-character lines and saturating holds: full-line cases
        set_config(16'hFFFF, 8'hFF, 16'hFFFF, 6'd1);
        queue_req(OP_CLEAR, 8'h00);
        queue_req(OP_CHAR, "a");
        queue_req(OP_CHAR, "b");            // full first line, then written
        queue_req(OP_CHAR, "c");            // full second line drops it
        queue_req(OP_CLEAR, 8'h00);
        queue_req(OP_CHAR, "a");
        queue_req(OP_CHAR, CHAR_BREAK);     // used up by the move
        queue_req(OP_CLEAR, 8'h00);
        queue_req(OP_CHAR, "a");
        queue_req(OP_CHAR, CHAR_NUL);       // moves and ends
        drain();

        // Low extremes and 40-character lines, no idling on either side
        set_config(16'd0, 8'd1, 16'd0, 6'd40);
        quiet_mode = 1'b1;
        queue_random_mix(RANDOM_PER_SET);
        drain();
        quiet_mode = 1'b0;

        // Zero strobe and zero line length; long receiver hold-off fills the block
        set_config(16'hFFFF, 8'd0, 16'hFFFF, 6'd0);
        hold_off_ask = hold_off_ask + 1;
        queue_random_mix(RANDOM_PER_SET);
        drain();

        // Short lines, random timing
        set_config(16'($urandom_range(0, 65535)), 8'($urandom_range(1, 255)),
                   16'($urandom_range(0, 65535)), 6'($urandom_range(1, 8)));
        queue_random_mix(RANDOM_PER_SET);
        drain();

        set_config(16'($urandom_range(0, 65000)), 8'($urandom_range(1, 255)),
                   16'($urandom_range(0, 65000)), 6'($urandom_range(1, 40)));
        queue_random_mix(RANDOM_PER_SET);
        drain();

        if (err_count == 0 && pin_phases_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
